[src/rypp_pkg.sv]
// ----------------------------------------------------------------------------
// rypp_pkg
// Shared types, format codes and BT.601 coefficients for the pixel packer.
// ----------------------------------------------------------------------------
package rypp_pkg;

   // source pixel format codes
   localparam logic [2:0] FMT_RGB565   = 3'd0;
   localparam logic [2:0] FMT_ARGB4444 = 3'd1;
   localparam logic [2:0] FMT_RGBA4444 = 3'd2;
   localparam logic [2:0] FMT_ABGR4444 = 3'd3;
   localparam logic [2:0] FMT_ABGR8888 = 3'd4;

   // BT.601 limited-range coefficients (magnitudes, signs applied in the adders)
   localparam logic [7:0] C_YR = 8'd66;
   localparam logic [7:0] C_YG = 8'd129;
   localparam logic [7:0] C_YB = 8'd25;
   localparam logic [7:0] C_UR = 8'd38;
   localparam logic [7:0] C_UG = 8'd74;
   localparam logic [7:0] C_UB = 8'd112;
   localparam logic [7:0] C_VR = 8'd112;
   localparam logic [7:0] C_VG = 8'd94;
   localparam logic [7:0] C_VB = 8'd18;

   // rounding term and output offsets
   localparam logic [7:0] ROUND_TERM = 8'd128;
   localparam logic [7:0] Y_OFFSET   = 8'd16;
   localparam logic [7:0] C_OFFSET   = 8'd128;

   // unpacked 8-bit components
   typedef struct packed {
      logic [2:0] fmt;
      logic [3:0] a;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgba_type;

   // registered coefficient products
   typedef struct packed {
      logic [2:0]  fmt;
      logic [3:0]  a;
      logic [15:0] yr;
      logic [15:0] yg;
      logic [15:0] yb;
      logic [15:0] ur;
      logic [15:0] ug;
      logic [15:0] ub;
      logic [15:0] vr;
      logic [15:0] vg;
      logic [15:0] vb;
   } prod_type;

   // 8-bit luma and chroma
   typedef struct packed {
      logic [2:0] fmt;
      logic [3:0] a;
      logic [7:0] y;
      logic [7:0] u;
      logic [7:0] v;
   } yuva_type;

endpackage

[src/rgb_to_yuv_pixel_packer.sv]
// ----------------------------------------------------------------------------
// rgb_to_yuv_pixel_packer
// RGB to BT.601 limited-range YUV converter with packed 16-bit output.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  input     req_pixel_in                  start, busy (busy is always low)
//  result    rsp_pixel_out                 rsp_valid, one-cycle strobe
//  config    csr_wr_data                   csr_wr_en, single register
//
//  One word enters per clock; its result is strobed once it has passed through
//  the unpack, multiply, sum and pack register stages.
//  Synchronous reset clears the pipeline valid bits and the format register.
//  The receiver takes every strobed word, so the pipeline never holds.
// ----------------------------------------------------------------------------
module rgb_to_yuv_pixel_packer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_pixel_in,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data,
   output logic        rsp_valid,
   output logic [15:0] rsp_pixel_out
);
   import rypp_pkg::*;

   logic [2:0] fmt_ff;
   logic       unp_valid;
   rgba_type   unp_comp;
   logic       mat_valid;
   yuva_type   mat_yuv;

   // format register
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_RGB565;
      end else if (csr_wr_en) begin
         fmt_ff <= csr_wr_data;
      end
   end

   // fully pipelined, never refuses a word
   assign busy = 1'b0;

   rypp_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_pixel  (req_pixel_in),
      .fmt       (fmt_ff),
      .out_valid (unp_valid),
      .out_comp  (unp_comp)
   );

   rypp_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (unp_valid),
      .in_comp   (unp_comp),
      .out_valid (mat_valid),
      .out_yuv   (mat_yuv)
   );

   rypp_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .in_yuv    (mat_yuv),
      .out_valid (rsp_valid),
      .out_pixel (rsp_pixel_out)
   );

endmodule

[src/rypp_unpack.sv]
// ----------------------------------------------------------------------------
// rypp_unpack
// Stage 1: splits the source word into 8-bit r, g, b and a 4-bit alpha.
// ----------------------------------------------------------------------------
module rypp_unpack (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [31:0]       in_pixel,
   input  logic [2:0]        fmt,
   output logic              out_valid,
   output rypp_pkg::rgba_type out_comp
);
   import rypp_pkg::*;

   rgba_type comp_in;
   rgba_type comp_ff;
   logic     valid_ff;

   // format-dependent field extraction, components left aligned in 8 bits
   always_comb begin
      comp_in     = '0;
      comp_in.fmt = fmt;
      unique case (fmt)
         FMT_RGB565: begin
            comp_in.r = {in_pixel[15:11], 3'b000};
            comp_in.g = {in_pixel[10:5], 2'b00};
            comp_in.b = {in_pixel[4:0], 3'b000};
         end
         FMT_ARGB4444: begin
            comp_in.a = in_pixel[15:12];
            comp_in.r = {in_pixel[11:8], 4'h0};
            comp_in.g = {in_pixel[7:4], 4'h0};
            comp_in.b = {in_pixel[3:0], 4'h0};
         end
         FMT_RGBA4444: begin
            comp_in.r = {in_pixel[15:12], 4'h0};
            comp_in.g = {in_pixel[11:8], 4'h0};
            comp_in.b = {in_pixel[7:4], 4'h0};
            comp_in.a = in_pixel[3:0];
         end
         FMT_ABGR4444: begin
            comp_in.a = in_pixel[15:12];
            comp_in.b = {in_pixel[11:8], 4'h0};
            comp_in.g = {in_pixel[7:4], 4'h0};
            comp_in.r = {in_pixel[3:0], 4'h0};
         end
         FMT_ABGR8888: begin
            // top nibble of each byte
            comp_in.a = in_pixel[31:28];
            comp_in.b = {in_pixel[23:20], 4'h0};
            comp_in.g = {in_pixel[15:12], 4'h0};
            comp_in.r = {in_pixel[7:4], 4'h0};
         end
         default: begin
            comp_in.a = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      comp_ff <= comp_in;
   end

   assign out_valid = valid_ff;
   assign out_comp  = comp_ff;

endmodule

[src/rypp_matrix.sv]
// ----------------------------------------------------------------------------
// rypp_matrix
// Stages 2 and 3: coefficient products, then sums with rounding, floor shift
// and offsets, giving 8-bit Y, U and V modulo 256.
// ----------------------------------------------------------------------------
module rypp_matrix (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rypp_pkg::rgba_type in_comp,
   output logic               out_valid,
   output rypp_pkg::yuva_type out_yuv
);
   import rypp_pkg::*;

   prod_type          prod_in;
   prod_type          prod_ff;
   logic              prod_valid_ff;
   logic [16:0]       y_sum;
   logic signed [17:0] u_sum;
   logic signed [17:0] v_sum;
   yuva_type          yuv_in;
   yuva_type          yuv_ff;
   logic              yuv_valid_ff;

   // stage 2: nine constant products
   always_comb begin
      prod_in.fmt = in_comp.fmt;
      prod_in.a   = in_comp.a;
      prod_in.yr  = 16'(in_comp.r) * 16'(C_YR);
      prod_in.yg  = 16'(in_comp.g) * 16'(C_YG);
      prod_in.yb  = 16'(in_comp.b) * 16'(C_YB);
      prod_in.ur  = 16'(in_comp.r) * 16'(C_UR);
      prod_in.ug  = 16'(in_comp.g) * 16'(C_UG);
      prod_in.ub  = 16'(in_comp.b) * 16'(C_UB);
      prod_in.vr  = 16'(in_comp.r) * 16'(C_VR);
      prod_in.vg  = 16'(in_comp.g) * 16'(C_VG);
      prod_in.vb  = 16'(in_comp.b) * 16'(C_VB);
   end

   // stage 3: sums, U and V signed; bits 15:8 of a sum are its floored shift mod 256
   always_comb begin
      y_sum = 17'(prod_ff.yr) + 17'(prod_ff.yg) + 17'(prod_ff.yb) + 17'(ROUND_TERM);
      u_sum = $signed({2'b00, prod_ff.ub}) + $signed(18'(ROUND_TERM))
            - $signed({2'b00, prod_ff.ur}) - $signed({2'b00, prod_ff.ug});
      v_sum = $signed({2'b00, prod_ff.vr}) + $signed(18'(ROUND_TERM))
            - $signed({2'b00, prod_ff.vg}) - $signed({2'b00, prod_ff.vb});
      yuv_in.fmt = prod_ff.fmt;
      yuv_in.a   = prod_ff.a;
      yuv_in.y   = y_sum[15:8] + Y_OFFSET;
      yuv_in.u   = u_sum[15:8] + C_OFFSET;
      yuv_in.v   = v_sum[15:8] + C_OFFSET;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         yuv_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid;
         yuv_valid_ff  <= prod_valid_ff;
      end
      prod_ff <= prod_in;
      yuv_ff  <= yuv_in;
   end

   assign out_valid = yuv_valid_ff;
   assign out_yuv   = yuv_ff;

endmodule

[src/rypp_pack.sv]
// ----------------------------------------------------------------------------
// rypp_pack
// Stage 4: truncates Y, U, V to field widths and packs the output word.
// ----------------------------------------------------------------------------
module rypp_pack (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rypp_pkg::yuva_type in_yuv,
   output logic               out_valid,
   output logic [15:0]        out_pixel
);
   import rypp_pkg::*;

   logic [15:0] pixel_in;
   logic [15:0] pixel_ff;
   logic        valid_ff;

   // output packing per format
   always_comb begin
      unique case (in_yuv.fmt)
         FMT_RGB565: begin
            pixel_in = {in_yuv.u[7:3], in_yuv.y[7:2], in_yuv.v[7:3]};
         end
         FMT_ARGB4444, FMT_RGBA4444, FMT_ABGR4444, FMT_ABGR8888: begin
            pixel_in = {in_yuv.a, in_yuv.y[7:4], in_yuv.u[7:4], in_yuv.v[7:4]};
         end
         default: begin
            pixel_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      pixel_ff <= pixel_in;
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

endmodule

[bench/rgb_to_yuv_pixel_packer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_yuv_pixel_packer_tb
// Self-checking bench for the pixel packer. Source words are pushed through
// every pixel format, including the unused codes. A scoreboard computes the
// expected packed YUV word for each accepted pixel and compares it with the
// strobed output. The bench drains the pipeline before each format write and
// idles the sender in random bursts.
// ----------------------------------------------------------------------------
module rgb_to_yuv_pixel_packer_tb;
   import rypp_pkg::*;

   // codes with no source layout, these give a zero word
   localparam logic [2:0] FMT_RSVD5 = 3'd5;
   localparam logic [2:0] FMT_RSVD6 = 3'd6;
   localparam logic [2:0] FMT_RSVD7 = 3'd7;

   localparam int PIPE_DEPTH    = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_COUNT   = 14;
   localparam int PHASE_WORDS   = 125;
   localparam int REPORT_LINES  = 40;

   // expected packed words, tracked against the active format
   class yuv_word_tracker;
      logic [2:0]  fmt;
      logic [15:0] packed_due[$];
      int          words_in;
      int          words_out;
      int          mismatches;

      function new();
         fmt = FMT_RGB565;
         words_in = 0;
         words_out = 0;
         mismatches = 0;
      endfunction

      function void set_format(input logic [2:0] f);
         fmt = f;
      endfunction

      function int pending();
         return packed_due.size();
      endfunction

      // bt.601 limited range, floor shift, kept to 8 bits
      function void bt601(input int r, input int g, input int b,
                          output logic [7:0] y, output logic [7:0] u,
                          output logic [7:0] v);
         int ys;
         int us;
         int vs;
         ys = ((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16;
         us = ((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128;
         vs = ((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128;
         y = ys[7:0];
         u = us[7:0];
         v = vs[7:0];
      endfunction

      function logic [15:0] pack_yuv(input logic [2:0] f, input logic [31:0] pix);
         logic [15:0] p;
         logic [15:0] w;
         logic [3:0]  a;
         logic [7:0]  y;
         logic [7:0]  u;
         logic [7:0]  v;
         int          r;
         int          g;
         int          b;
         p = pix[15:0];
         case (f)
            FMT_RGB565: begin
               r = int'({p[15:11], 3'b000});
               g = int'({p[10:5], 2'b00});
               b = int'({p[4:0], 3'b000});
               bt601(r, g, b, y, u, v);
               return {u[7:3], y[7:2], v[7:3]};
            end
            FMT_ARGB4444: begin
               a = p[15:12];
               r = int'({p[11:8], 4'h0});
               g = int'({p[7:4], 4'h0});
               b = int'({p[3:0], 4'h0});
            end
            FMT_RGBA4444: begin
               a = p[3:0];
               r = int'({p[15:12], 4'h0});
               g = int'({p[11:8], 4'h0});
               b = int'({p[7:4], 4'h0});
            end
            FMT_ABGR4444, FMT_ABGR8888: begin
               // 8888 keeps the top nibble of each byte
               if (f == FMT_ABGR8888) begin
                  w = {pix[31:28], pix[23:20], pix[15:12], pix[7:4]};
               end else begin
                  w = p;
               end
               a = w[15:12];
               r = int'({w[3:0], 4'h0});
               g = int'({w[7:4], 4'h0});
               b = int'({w[11:8], 4'h0});
            end
            default: begin
               return 16'h0000;
            end
         endcase
         bt601(r, g, b, y, u, v);
         return {a, y[7:4], u[7:4], v[7:4]};
      endfunction

      task report(input string msg);
         if (mismatches < REPORT_LINES) begin
            $display("mismatch: %s", msg);
         end
         mismatches++;
      endtask

      function void note_pixel(input logic [31:0] pix);
         packed_due.push_back(pack_yuv(fmt, pix));
         words_in++;
      endfunction

      task check_word(input logic [15:0] got);
         logic [15:0] want;
         words_out++;
         if (packed_due.size() == 0) begin
            report($sformatf("word %04h with nothing expected", got));
         end else begin
            want = packed_due.pop_front();
            if (got !== want) begin
               report($sformatf("pixel_out %04h, expected %04h (result %0d)",
                                got, want, words_out));
            end
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_pixel_in = 32'h0;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_wr_data = 3'd0;
   logic        rsp_valid;
   logic [15:0] rsp_pixel_out;

   yuv_word_tracker sb = new();
   logic [2:0]      cur_fmt = FMT_RGB565;
   int              settings_used = 0;
   int              cycle_count = 0;

   rgb_to_yuv_pixel_packer i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_pixel_in  (req_pixel_in),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out)
   );

   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // sample handshakes at the edge, inputs before results before csr
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_pixel(req_pixel_in);
         end
         if (rsp_valid) begin
            sb.check_word(rsp_pixel_out);
         end
         if (csr_wr_en) begin
            sb.set_format(csr_wr_data);
         end
      end
   end

   // one word with an optional idle burst ahead of it
   task feed_pixel(input logic [31:0] pix, input int gap_odds);
      if (gap_odds > 0 && $urandom_range(1, gap_odds) == 1) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      start <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (busy);
   endtask

   // hold the sender until every expected word is back
   task settle_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   task switch_format(input logic [2:0] f);
      settle_pipeline();
      csr_wr_en <= 1'b1;
      csr_wr_data <= f;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_fmt = f;
      settings_used++;
   endtask

   task apply_case(input logic [2:0] f, input logic [31:0] pix);
      if (f != cur_fmt) begin
         switch_format(f);
      end
      feed_pixel(pix, 0);
   endtask

   // nibbles pinned to zero, full scale or left random
   function logic [31:0] corner_pixel();
      logic [31:0] pix;
      pix = $urandom;
      for (int i = 0; i < 8; i++) begin
         case ($urandom_range(0, 2))
            0: pix[i*4 +: 4] = 4'h0;
            1: pix[i*4 +: 4] = 4'hF;
            default: ;
         endcase
      end
      return pix;
   endfunction

   initial begin
      logic [2:0]  phase_fmt;
      logic [31:0] pix;
      int          gap_odds;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes in every format, ignored upper bits,
      // nibble extraction in 8888, unused codes
      apply_case(FMT_RGB565,   32'h0000_0000);
      apply_case(FMT_RGB565,   32'h0000_FFFF);
      apply_case(FMT_RGB565,   32'h0000_F800);
      apply_case(FMT_RGB565,   32'h0000_07E0);
      apply_case(FMT_RGB565,   32'h0000_001F);
      apply_case(FMT_RGB565,   32'hFFFF_0000);
      apply_case(FMT_ARGB4444, 32'h0000_F000);
      apply_case(FMT_ARGB4444, 32'hFFFF_0FFF);
      apply_case(FMT_RGBA4444, 32'h0000_FFF0);
      apply_case(FMT_RGBA4444, 32'h0000_000F);
      apply_case(FMT_ABGR4444, 32'h0000_0F00);
      apply_case(FMT_ABGR4444, 32'hFFFF_F00F);
      apply_case(FMT_ABGR8888, 32'hFFFF_FFFF);
      apply_case(FMT_ABGR8888, 32'h0F0F_0F0F);
      apply_case(FMT_ABGR8888, 32'hF000_0000);
      apply_case(FMT_ABGR8888, 32'h00F0_F0F0);
      apply_case(FMT_RSVD5,    32'hFFFF_FFFF);
      apply_case(FMT_RSVD6,    32'hFFFF_FFFF);
      apply_case(FMT_RSVD7,    32'hFFFF_FFFF);

      // random phases: every code once in order, then random codes
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 8) begin
            phase_fmt = 3'(phase);
         end else begin
            phase_fmt = 3'($urandom_range(0, 7));
         end
         switch_format(phase_fmt);
         case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 4;
            default: gap_odds = 16;
         endcase
         if (phase == PHASE_COUNT - 1) begin
            gap_odds = 0;
         end
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if ($urandom_range(0, 3) == 0) begin
               pix = corner_pixel();
            end else begin
               pix = $urandom;
            end
            feed_pixel(pix, gap_odds);
         end
      end

      settle_pipeline();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d words never came out", sb.pending()));
      end

      $display("checked %0d packed words from %0d pixels over %0d format writes",
               sb.words_out, sb.words_in, settings_used);
      $display("all eight format codes, idle bursts and back-to-back streams covered");
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
